// ----- src/pidaw_pkg.sv -----
package pidaw_pkg;

   localparam int POS_W       = 32;
   localparam int COEF_W      = 24;
   localparam int WEIGHT_W    = 17;
   localparam int WEIGHT_FRAC = 16;
   localparam int LIMIT_W     = 16;
   localparam int DUTY_W      = 16;
   localparam int DIR_W       = 2;
   localparam int STATE_W     = 48;
   localparam int HALF_W      = STATE_W / 2;
   localparam int RESID_W     = 18;
   localparam int FRAC_W      = 8;
   localparam int SUM_W       = STATE_W + 2;
   localparam int MAG_W       = SUM_W - FRAC_W;

   localparam int MUL_A_W = COEF_W + 1;
   localparam int MUL_B_W = (POS_W + 2 > RESID_W + FRAC_W) ? POS_W + 2 : RESID_W + FRAC_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = (STATE_W + WEIGHT_W + 1 > PROD_W + 2) ?
                            STATE_W + WEIGHT_W + 1 : PROD_W + 2;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = COEF_W;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << WEIGHT_FRAC);

   localparam logic [COEF_W-1:0]   PROP_GAIN_RST     = 24'd57322;
   localparam logic [COEF_W-1:0]   INTEG_GAIN_RST    = 24'd5923;
   localparam logic [COEF_W-1:0]   DERIV_GAIN_RST    = 24'd118174;
   localparam logic [COEF_W-1:0]   BACKCALC_GAIN_RST = 24'd14672;
   localparam logic [WEIGHT_W-1:0] FILTER_WEIGHT_RST = 17'd39322;
   localparam logic [LIMIT_W-1:0]  DUTY_HIGH_RST     = 16'd400;
   localparam logic [LIMIT_W-1:0]  DUTY_LOW_RST      = 16'd0;

   localparam logic [DIR_W-1:0] DIR_FORWARD = 2'd0;
   localparam logic [DIR_W-1:0] DIR_REVERSE = 2'd1;
   localparam logic [DIR_W-1:0] DIR_STOP    = 2'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PROP_GAIN     = 3'd0,
      CSR_INTEG_GAIN    = 3'd1,
      CSR_DERIV_GAIN    = 3'd2,
      CSR_BACKCALC_GAIN = 3'd3,
      CSR_FILTER_WEIGHT = 3'd4,
      CSR_DUTY_HIGH     = 3'd5,
      CSR_DUTY_LOW      = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [POS_W-1:0] target_position;
      logic signed [POS_W-1:0] measured_position;
   } req_word_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty;
      logic [DIR_W-1:0]  direction;
      logic              clamped;
   } rsp_word_type;

   typedef struct packed {
      logic [COEF_W-1:0]   prop_gain;
      logic [COEF_W-1:0]   integral_gain_period;
      logic [COEF_W-1:0]   deriv_gain_over_period;
      logic [COEF_W-1:0]   backcalc_gain_period;
      logic [WEIGHT_W-1:0] filter_weight;
      logic [LIMIT_W-1:0]  duty_high_limit;
      logic [LIMIT_W-1:0]  duty_low_limit;
   } cfg_type;

   typedef enum logic [2:0] {
      A_NONE,
      A_PROP,
      A_INTEG,
      A_BACKCALC,
      A_DERIV,
      A_WEIGHT,
      A_WEIGHT_INV
   } a_sel_type;

   typedef enum logic [2:0] {
      B_NONE,
      B_ERROR,
      B_DELTA,
      B_RESIDUAL,
      B_DERIV_LO,
      B_DERIV_HI,
      B_FILT_LO,
      B_FILT_HI
   } b_sel_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_DELTA,
      ACT_PROP,
      ACT_DERIV,
      ACT_INTEG_LOAD,
      ACT_INTEG_STORE,
      ACT_FILT_LOAD,
      ACT_FILT_ADD_HI,
      ACT_FILT_ADD_LO,
      ACT_FILT_STORE,
      ACT_SUM,
      ACT_MAG,
      ACT_CLAMP,
      ACT_EMIT
   } act_type;

   typedef enum logic {
      SEQ_NEXT,
      SEQ_EMIT
   } seq_type;

   typedef struct packed {
      a_sel_type a_sel;
      b_sel_type b_sel;
      act_type   act;
      seq_type   seq;
   } ctl_word_type;

   localparam int STEP_COUNT = 13;
   localparam int STEP_W     = $clog2(STEP_COUNT);

   localparam ctl_word_type CTL_IDLE = '{A_NONE, B_NONE, ACT_NONE, SEQ_NEXT};

   function automatic ctl_word_type ucode(input logic [STEP_W-1:0] step);
      ctl_word_type word;
      case (step)
         STEP_W'(0):  word = '{A_PROP,       B_ERROR,    ACT_DELTA,       SEQ_NEXT};
         STEP_W'(1):  word = '{A_DERIV,      B_DELTA,    ACT_PROP,        SEQ_NEXT};
         STEP_W'(2):  word = '{A_INTEG,      B_ERROR,    ACT_DERIV,       SEQ_NEXT};
         STEP_W'(3):  word = '{A_BACKCALC,   B_RESIDUAL, ACT_INTEG_LOAD,  SEQ_NEXT};
         STEP_W'(4):  word = '{A_WEIGHT,     B_DERIV_LO, ACT_INTEG_STORE, SEQ_NEXT};
         STEP_W'(5):  word = '{A_WEIGHT,     B_DERIV_HI, ACT_FILT_LOAD,   SEQ_NEXT};
         STEP_W'(6):  word = '{A_WEIGHT_INV, B_FILT_LO,  ACT_FILT_ADD_HI, SEQ_NEXT};
         STEP_W'(7):  word = '{A_WEIGHT_INV, B_FILT_HI,  ACT_FILT_ADD_LO, SEQ_NEXT};
         STEP_W'(8):  word = '{A_NONE,       B_NONE,     ACT_FILT_STORE,  SEQ_NEXT};
         STEP_W'(9):  word = '{A_NONE,       B_NONE,     ACT_SUM,         SEQ_NEXT};
         STEP_W'(10): word = '{A_NONE,       B_NONE,     ACT_MAG,         SEQ_NEXT};
         STEP_W'(11): word = '{A_NONE,       B_NONE,     ACT_CLAMP,       SEQ_NEXT};
         STEP_W'(12): word = '{A_NONE,       B_NONE,     ACT_EMIT,        SEQ_EMIT};
         default:     word = CTL_IDLE;
      endcase
      return word;
   endfunction

   function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
      logic [ACC_W-STATE_W:0] hi_bits;
      logic signed [STATE_W-1:0] res;
      hi_bits = v[ACC_W-1:STATE_W-1];
      if (hi_bits == '0 || hi_bits == '1) begin
         res = v[STATE_W-1:0];
      end else if (v[ACC_W-1]) begin
         res = {1'b1, {(STATE_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(STATE_W-1){1'b1}}};
      end
      return res;
   endfunction

endpackage

// ----- src/pidaw_sequencer.sv -----
module pidaw_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    out_free,
   output logic                    busy,
   output pidaw_pkg::ctl_word_type ctl
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } seq_state_type;

   seq_state_type                  state_ff, state_in;
   logic [pidaw_pkg::STEP_W-1:0]   step_ff, step_in;

   assign busy = (state_ff == ST_RUN);

   always_comb begin
      if (state_ff == ST_RUN) begin
         ctl = pidaw_pkg::ucode(step_ff);
      end else begin
         ctl = pidaw_pkg::CTL_IDLE;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
               step_in  = '0;
            end
         end
         ST_RUN: begin
            case (ctl.seq)
               pidaw_pkg::SEQ_NEXT: begin
                  step_in = step_ff + 1'b1;
               end
               pidaw_pkg::SEQ_EMIT: begin
                  if (out_free) begin
                     state_in = ST_IDLE;
                     step_in  = '0;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
                  step_in  = '0;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
            step_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ----- src/pidaw_datapath.sv -----
module pidaw_datapath #(
   parameter int COEF_FRACTION_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  pidaw_pkg::req_word_type req,
   input  pidaw_pkg::cfg_type      cfg,
   input  pidaw_pkg::ctl_word_type ctl,
   output pidaw_pkg::rsp_word_type result
);

   localparam int POS_W    = pidaw_pkg::POS_W;
   localparam int STATE_W  = pidaw_pkg::STATE_W;
   localparam int HALF_W   = pidaw_pkg::HALF_W;
   localparam int RESID_W  = pidaw_pkg::RESID_W;
   localparam int FRAC_W   = pidaw_pkg::FRAC_W;
   localparam int SUM_W    = pidaw_pkg::SUM_W;
   localparam int MAG_W    = pidaw_pkg::MAG_W;
   localparam int DUTY_W   = pidaw_pkg::DUTY_W;
   localparam int DIR_W    = pidaw_pkg::DIR_W;
   localparam int WEIGHT_W = pidaw_pkg::WEIGHT_W;
   localparam int MUL_A_W  = pidaw_pkg::MUL_A_W;
   localparam int MUL_B_W  = pidaw_pkg::MUL_B_W;
   localparam int PROD_W   = pidaw_pkg::PROD_W;
   localparam int ACC_W    = pidaw_pkg::ACC_W;

   logic signed [POS_W-1:0]   last_error_ff, last_error_in;
   logic signed [STATE_W-1:0] integ_ff, integ_in;
   logic signed [STATE_W-1:0] udf_ff, udf_in;
   logic signed [RESID_W-1:0] resid_ff, resid_in;

   logic signed [POS_W-1:0]   e_ff, e_in;
   logic signed [POS_W:0]     de_ff, de_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [STATE_W-1:0] up_ff, up_in;
   logic signed [STATE_W-1:0] ud_ff, ud_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [MAG_W-1:0]          mag_ff, mag_in;
   logic [DIR_W-1:0]          dir_ff, dir_in;
   logic [DUTY_W-1:0]         duty_ff, duty_in;
   logic                      clamped_ff, clamped_in;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic [POS_W:0]            pos_diff;
   logic signed [ACC_W-1:0]   prod_ext;
   logic signed [ACC_W-1:0]   prod_shr;
   logic signed [ACC_W-1:0]   prod_hi;
   logic signed [ACC_W-1:0]   integ_ext;
   logic signed [ACC_W-1:0]   filt_total;
   logic signed [ACC_W-1:0]   filt_shr;
   logic [SUM_W-1:0]          abs_sum;
   logic [MAG_W-1:0]          high_ext;
   logic [MAG_W-1:0]          low_ext;
   logic [DUTY_W-1:0]         duty_sel;
   logic                      clamp_sel;
   logic [MAG_W-1:0]          duty_ext;
   logic signed [MAG_W+1:0]   resid_diff;
   logic [MAG_W+2-RESID_W:0]  resid_hi;
   logic signed [RESID_W-1:0] resid_sat;

   always_comb begin
      case (ctl.a_sel)
         pidaw_pkg::A_PROP:       mul_a = {1'b0, cfg.prop_gain};
         pidaw_pkg::A_INTEG:      mul_a = {1'b0, cfg.integral_gain_period};
         pidaw_pkg::A_BACKCALC:   mul_a = {1'b0, cfg.backcalc_gain_period};
         pidaw_pkg::A_DERIV:      mul_a = {1'b0, cfg.deriv_gain_over_period};
         pidaw_pkg::A_WEIGHT:     mul_a = {{(MUL_A_W-WEIGHT_W){1'b0}}, cfg.filter_weight};
         pidaw_pkg::A_WEIGHT_INV: mul_a = {{(MUL_A_W-WEIGHT_W){1'b0}},
                                           pidaw_pkg::WEIGHT_ONE - cfg.filter_weight};
         default:                 mul_a = '0;
      endcase
   end

   always_comb begin
      case (ctl.b_sel)
         pidaw_pkg::B_ERROR:    mul_b = {{(MUL_B_W-POS_W){e_ff[POS_W-1]}}, e_ff};
         pidaw_pkg::B_DELTA:    mul_b = {{(MUL_B_W-POS_W-1){de_ff[POS_W]}}, de_ff};
         pidaw_pkg::B_RESIDUAL: mul_b = {{(MUL_B_W-RESID_W-FRAC_W){resid_ff[RESID_W-1]}},
                                         resid_ff, {FRAC_W{1'b0}}};
         pidaw_pkg::B_DERIV_LO: mul_b = {{(MUL_B_W-HALF_W){1'b0}}, ud_ff[HALF_W-1:0]};
         pidaw_pkg::B_DERIV_HI: mul_b = {{(MUL_B_W-HALF_W){ud_ff[STATE_W-1]}},
                                         ud_ff[STATE_W-1:HALF_W]};
         pidaw_pkg::B_FILT_LO:  mul_b = {{(MUL_B_W-HALF_W){1'b0}}, udf_ff[HALF_W-1:0]};
         pidaw_pkg::B_FILT_HI:  mul_b = {{(MUL_B_W-HALF_W){udf_ff[STATE_W-1]}},
                                         udf_ff[STATE_W-1:HALF_W]};
         default:               mul_b = '0;
      endcase
   end

   assign prod_in    = mul_a * mul_b;
   assign pos_diff   = {req.target_position[POS_W-1], req.target_position}
                     - {req.measured_position[POS_W-1], req.measured_position};
   assign prod_ext   = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign prod_shr   = prod_ext >>> COEF_FRACTION_BITS;
   assign prod_hi    = prod_ext <<< HALF_W;
   assign integ_ext  = {{(ACC_W-STATE_W){integ_ff[STATE_W-1]}}, integ_ff};
   assign filt_total = acc_ff + prod_hi;
   assign filt_shr   = filt_total >>> pidaw_pkg::WEIGHT_FRAC;
   assign abs_sum    = sum_ff[SUM_W-1] ? -sum_ff : sum_ff;
   assign high_ext   = {{(MAG_W-DUTY_W){1'b0}}, cfg.duty_high_limit};
   assign low_ext    = {{(MAG_W-DUTY_W){1'b0}}, cfg.duty_low_limit};

   always_comb begin
      if (mag_ff > high_ext) begin
         duty_sel  = cfg.duty_high_limit;
         clamp_sel = 1'b1;
      end else if (mag_ff < low_ext) begin
         duty_sel  = cfg.duty_low_limit;
         clamp_sel = 1'b1;
      end else begin
         duty_sel  = mag_ff[DUTY_W-1:0];
         clamp_sel = 1'b0;
      end
   end

   assign duty_ext = {{(MAG_W-DUTY_W){1'b0}}, duty_sel};

   always_comb begin
      if (dir_ff == pidaw_pkg::DIR_REVERSE) begin
         resid_diff = {2'b00, mag_ff} - {2'b00, duty_ext};
      end else begin
         resid_diff = {2'b00, duty_ext} - {2'b00, mag_ff};
      end
      resid_hi = resid_diff[MAG_W+1:RESID_W-1];
      if (dir_ff == pidaw_pkg::DIR_STOP) begin
         resid_sat = '0;
      end else if (resid_hi == '0 || resid_hi == '1) begin
         resid_sat = resid_diff[RESID_W-1:0];
      end else if (resid_diff[MAG_W+1]) begin
         resid_sat = {1'b1, {(RESID_W-1){1'b0}}};
      end else begin
         resid_sat = {1'b0, {(RESID_W-1){1'b1}}};
      end
   end

   always_comb begin
      last_error_in = last_error_ff;
      integ_in      = integ_ff;
      udf_in        = udf_ff;
      resid_in      = resid_ff;
      e_in          = e_ff;
      de_in         = de_ff;
      acc_in        = acc_ff;
      up_in         = up_ff;
      ud_in         = ud_ff;
      sum_in        = sum_ff;
      mag_in        = mag_ff;
      dir_in        = dir_ff;
      duty_in       = duty_ff;
      clamped_in    = clamped_ff;

      if (load) begin
         if (pos_diff[POS_W] != pos_diff[POS_W-1]) begin
            e_in = pos_diff[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
         end else begin
            e_in = pos_diff[POS_W-1:0];
         end
      end

      case (ctl.act)
         pidaw_pkg::ACT_DELTA: begin
            de_in         = {e_ff[POS_W-1], e_ff} - {last_error_ff[POS_W-1], last_error_ff};
            last_error_in = e_ff;
         end
         pidaw_pkg::ACT_PROP: begin
            up_in = pidaw_pkg::sat_state(prod_shr);
         end
         pidaw_pkg::ACT_DERIV: begin
            ud_in = pidaw_pkg::sat_state(prod_shr);
         end
         pidaw_pkg::ACT_INTEG_LOAD: begin
            acc_in = integ_ext + prod_shr;
         end
         pidaw_pkg::ACT_INTEG_STORE: begin
            integ_in = pidaw_pkg::sat_state(acc_ff + prod_shr);
         end
         pidaw_pkg::ACT_FILT_LOAD: begin
            acc_in = prod_ext;
         end
         pidaw_pkg::ACT_FILT_ADD_HI: begin
            acc_in = acc_ff + prod_hi;
         end
         pidaw_pkg::ACT_FILT_ADD_LO: begin
            acc_in = acc_ff + prod_ext;
         end
         pidaw_pkg::ACT_FILT_STORE: begin
            udf_in = pidaw_pkg::sat_state(filt_shr);
         end
         pidaw_pkg::ACT_SUM: begin
            sum_in = {{(SUM_W-STATE_W){up_ff[STATE_W-1]}}, up_ff}
                   + {{(SUM_W-STATE_W){integ_ff[STATE_W-1]}}, integ_ff}
                   + {{(SUM_W-STATE_W){udf_ff[STATE_W-1]}}, udf_ff};
         end
         pidaw_pkg::ACT_MAG: begin
            mag_in = abs_sum[SUM_W-1:FRAC_W];
            if (sum_ff == '0) begin
               dir_in = pidaw_pkg::DIR_STOP;
            end else if (sum_ff[SUM_W-1]) begin
               dir_in = pidaw_pkg::DIR_REVERSE;
            end else begin
               dir_in = pidaw_pkg::DIR_FORWARD;
            end
         end
         pidaw_pkg::ACT_CLAMP: begin
            duty_in    = duty_sel;
            clamped_in = clamp_sel;
            resid_in   = resid_sat;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff <= '0;
         integ_ff      <= '0;
         udf_ff        <= '0;
         resid_ff      <= '0;
      end else begin
         last_error_ff <= last_error_in;
         integ_ff      <= integ_in;
         udf_ff        <= udf_in;
         resid_ff      <= resid_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff       <= e_in;
      de_ff      <= de_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      up_ff      <= up_in;
      ud_ff      <= ud_in;
      sum_ff     <= sum_in;
      mag_ff     <= mag_in;
      dir_ff     <= dir_in;
      duty_ff    <= duty_in;
      clamped_ff <= clamped_in;
   end

   always_comb begin
      result.duty      = duty_ff;
      result.direction = dir_ff;
      result.clamped   = clamped_ff;
   end

endmodule

// ----- src/pid_antiwindup_filtered_derivative_core.sv -----
// PID position controller with back-calculation anti-windup and a filtered
// derivative term, in fixed point.
// req channel: one word per servo sample (setpoint and measured position),
// taken when req_valid is high and req_stall is low. req_stall stays high
// while a sample is being worked on.
// rsp channel: one word per sample (duty, direction, clamped), held in an
// output register until taken with rsp_valid high and rsp_stall low.
// csr channel: register index and data, written when csr_valid and
// csr_ready are high; csr_ready is always high. Write only while idle.
// A microcoded program of 13 steps drives one shared multiplier through
// eight products and then the sum, magnitude and clamp steps. The next
// sample is taken the cycle after the result is loaded.
// When the receiver stalls, the last step holds until the output register
// frees; a waiting result does not block the next sample.
// Reset returns all gains and limits to their defaults and clears the last
// error, integral, filtered derivative and windup residual.
module pid_antiwindup_filtered_derivative_core #(
   parameter int COEF_FRACTION_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  pidaw_pkg::req_word_type                req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output pidaw_pkg::rsp_word_type                rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [pidaw_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [pidaw_pkg::CSR_DATA_W-1:0]       csr_data
);

   pidaw_pkg::cfg_type      cfg_ff, cfg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   pidaw_pkg::rsp_word_type rsp_data_ff, rsp_data_in;

   pidaw_pkg::ctl_word_type ctl;
   pidaw_pkg::rsp_word_type result;
   logic                    busy;
   logic                    start;
   logic                    out_free;
   logic                    emit;
   logic [pidaw_pkg::WEIGHT_W-1:0] weight_wr;

   assign csr_ready = 1'b1;
   assign req_stall = busy;
   assign start     = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = (ctl.act == pidaw_pkg::ACT_EMIT) && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign weight_wr = csr_data[pidaw_pkg::WEIGHT_W-1:0];

   pidaw_sequencer u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_free (out_free),
      .busy     (busy),
      .ctl      (ctl)
   );

   pidaw_datapath #(
      .COEF_FRACTION_BITS (COEF_FRACTION_BITS)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .load   (start),
      .req    (req_data),
      .cfg    (cfg_ff),
      .ctl    (ctl),
      .result (result)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            pidaw_pkg::CSR_PROP_GAIN:     cfg_in.prop_gain = csr_data;
            pidaw_pkg::CSR_INTEG_GAIN:    cfg_in.integral_gain_period = csr_data;
            pidaw_pkg::CSR_DERIV_GAIN:    cfg_in.deriv_gain_over_period = csr_data;
            pidaw_pkg::CSR_BACKCALC_GAIN: cfg_in.backcalc_gain_period = csr_data;
            pidaw_pkg::CSR_FILTER_WEIGHT: begin
               if (weight_wr > pidaw_pkg::WEIGHT_ONE) begin
                  cfg_in.filter_weight = pidaw_pkg::WEIGHT_ONE;
               end else begin
                  cfg_in.filter_weight = weight_wr;
               end
            end
            pidaw_pkg::CSR_DUTY_HIGH:
               cfg_in.duty_high_limit = csr_data[pidaw_pkg::LIMIT_W-1:0];
            pidaw_pkg::CSR_DUTY_LOW:
               cfg_in.duty_low_limit = csr_data[pidaw_pkg::LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain              <= pidaw_pkg::PROP_GAIN_RST;
         cfg_ff.integral_gain_period   <= pidaw_pkg::INTEG_GAIN_RST;
         cfg_ff.deriv_gain_over_period <= pidaw_pkg::DERIV_GAIN_RST;
         cfg_ff.backcalc_gain_period   <= pidaw_pkg::BACKCALC_GAIN_RST;
         cfg_ff.filter_weight          <= pidaw_pkg::FILTER_WEIGHT_RST;
         cfg_ff.duty_high_limit        <= pidaw_pkg::DUTY_HIGH_RST;
         cfg_ff.duty_low_limit         <= pidaw_pkg::DUTY_LOW_RST;
         rsp_valid_ff                  <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      start |=> req_stall)
      else $error("sample accepted but sequencer did not start");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid)
      else $error("emit step did not load the output register");

   a_weight_bound: assert property (@(posedge clock) disable iff (reset)
      cfg_ff.filter_weight <= pidaw_pkg::WEIGHT_ONE)
      else $error("filter weight above one");

   a_duty_in_limits: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.clamped) |->
         (rsp_data.duty <= cfg_ff.duty_high_limit) &&
         (rsp_data.duty >= cfg_ff.duty_low_limit))
      else $error("unclamped duty outside limits");

endmodule
